// ===== rtl/core/anchored_wildcard_word_match_unit_defines.svh =====
// Assertion helpers for the word matcher.
`ifndef ANCHORED_WILDCARD_WORD_MATCH_UNIT_DEFINES_SVH
`define ANCHORED_WILDCARD_WORD_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define AWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define AWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/awm_pkg.sv =====
package awm_pkg;

    localparam int CHAR_W          = 8;
    localparam int PATTERN_SLOTS   = 32;
    localparam int PATTERN_MAX_DEF = 32;
    localparam int CFG_W           = 64;
    localparam int LEN_W           = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int PAT_BITS        = PATTERN_SLOTS * CHAR_W;

    localparam logic [CHAR_W-1:0] WILDCARD = 8'h2E;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT3       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_BEG = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_END = 3'd6;

    // Matcher state visible to the top level
    typedef struct packed {
        logic at_start;
        logic found;
    } awm_status_t;

endpackage

// ===== rtl/core/awm_cmp.sv =====
module awm_cmp
    import awm_pkg::*;
#(
    parameter int VEC_W = PATTERN_SLOTS
)
(
    input  logic [PAT_BITS-1:0] pattern,
    input  logic [CHAR_W-1:0]   ch,
    output logic [VEC_W-1:0]    mask
);

    // one comparator per pattern position
    always_comb
    begin
        for (int i = 0; i < VEC_W; i++)
        begin
            mask[i] = (pattern[i*CHAR_W +: CHAR_W] == WILDCARD) ||
                      (pattern[i*CHAR_W +: CHAR_W] == ch);
        end
    end

endmodule

// ===== rtl/core/awm_core.sv =====
module awm_core
    import awm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                process,
    input  logic [CHAR_W-1:0]   ch,
    input  logic                last,
    input  logic [PAT_BITS-1:0] pattern,
    input  logic [LEN_W-1:0]    pattern_length,
    input  logic                anchor_start,
    input  logic                anchor_end,
    output logic                result,
    output awm_status_t         status
);

    localparam int VEC_W = (PATTERN_MAX < PATTERN_SLOTS) ? PATTERN_MAX : PATTERN_SLOTS;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(VEC_W);

    logic [VEC_W-1:0] pm_reg, pm_next;
    logic             at_start_reg, at_start_next;
    logic             found_reg, found_next;

    logic [LEN_W-1:0] len_eff;
    logic [VEC_W-1:0] keep, top, mask, shifted, pm_upd;
    logic [VEC_W:0]   shift_ext;
    logic             seed, full_here;

    awm_cmp #(.VEC_W(VEC_W)) u_cmp
    (
        .pattern (pattern),
        .ch      (ch),
        .mask    (mask)
    );

    assign len_eff = (pattern_length > LEN_CAP) ? LEN_CAP : pattern_length;

    always_comb
    begin
        for (int i = 0; i < VEC_W; i++)
        begin
            keep[i] = LEN_W'(i) < len_eff;
            top[i]  = len_eff == LEN_W'(i + 1);
        end
    end

    assign seed      = !anchor_start || at_start_reg;
    assign shift_ext = {pm_reg, seed};
    assign shifted   = shift_ext[VEC_W-1:0];
    assign pm_upd    = shifted & keep & mask;
    assign full_here = |(pm_upd & top);

    always_comb
    begin
        if (len_eff == '0)
            result = !(anchor_start && anchor_end);
        else if (anchor_end)
            result = full_here;
        else
            result = found_reg || full_here;
    end

    always_comb
    begin
        pm_next       = pm_reg;
        at_start_next = at_start_reg;
        found_next    = found_reg;
        if (process)
        begin
            if (last)
            begin
                pm_next       = '0;
                at_start_next = 1'b1;
                found_next    = 1'b0;
            end
            else
            begin
                pm_next       = pm_upd;
                at_start_next = 1'b0;
                found_next    = found_reg || full_here;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_reg       <= '0;
            at_start_reg <= 1'b1;
            found_reg    <= 1'b0;
        end
        else
        begin
            pm_reg       <= pm_next;
            at_start_reg <= at_start_next;
            found_reg    <= found_next;
        end
    end

    assign status.at_start = at_start_reg;
    assign status.found    = found_reg;

endmodule

// ===== rtl/core/anchored_wildcard_word_match_unit.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+--------------------------
// word     | word_valid / word_stall   | word_char[7:0], last_char
// match    | match_valid / match_stall | matched
// cfg      | cfg_we (no wait)          | cfg_index[2:0], cfg_data[63:0]
//
// One character beat per cycle while word_stall is low. A beat is held in the
// input register, then the comparators and shift-and update fold it into the
// word state; a last-character beat also loads the match register.
// Reset (rst_n low, async) empties both registers and restarts the word.
// match_stall holds only last-character beats; other beats keep flowing.
`include "anchored_wildcard_word_match_unit_defines.svh"

module anchored_wildcard_word_match_unit
    import awm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 word_valid,
    output logic                 word_stall,
    input  logic [CHAR_W-1:0]    word_char,
    input  logic                 last_char,

    output logic                 match_valid,
    input  logic                 match_stall,
    output logic                 matched,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers
    logic [CFG_W-1:0] pat0_reg, pat1_reg, pat2_reg, pat3_reg;
    logic [LEN_W-1:0] length_reg;
    logic             anchor_beg_reg, anchor_end_reg;

    // Input register
    logic              s1_valid_reg, s1_valid_next;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_last_reg;

    // Result register
    logic        match_valid_reg, match_valid_next;
    logic        matched_reg;

    logic        word_take, match_take, out_free, advance, core_result;
    awm_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat0_reg       <= '0;
            pat1_reg       <= '0;
            pat2_reg       <= '0;
            pat3_reg       <= '0;
            length_reg     <= '0;
            anchor_beg_reg <= 1'b0;
            anchor_end_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PAT0:       pat0_reg       <= cfg_data;
                REG_PAT1:       pat1_reg       <= cfg_data;
                REG_PAT2:       pat2_reg       <= cfg_data;
                REG_PAT3:       pat3_reg       <= cfg_data;
                REG_LENGTH:     length_reg     <= cfg_data[LEN_W-1:0];
                REG_ANCHOR_BEG: anchor_beg_reg <= cfg_data[0];
                REG_ANCHOR_END: anchor_end_reg <= cfg_data[0];
                default:        ;  // unmapped index, dropped
            endcase
        end
    end

    // A non-last beat never waits; a last beat waits for room in the result register.
    assign match_take = match_valid_reg && !match_stall;
    assign out_free   = !match_valid_reg || !match_stall;
    assign advance    = s1_valid_reg && (!s1_last_reg || out_free);
    assign word_stall = s1_valid_reg && !advance;
    assign word_take  = word_valid && !word_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (word_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (word_take)
        begin
            s1_char_reg <= word_char;
            s1_last_reg <= last_char;
        end
    end

    awm_core #(.PATTERN_MAX(PATTERN_MAX)) u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .process        (advance),
        .ch             (s1_char_reg),
        .last           (s1_last_reg),
        .pattern        ({pat3_reg, pat2_reg, pat1_reg, pat0_reg}),
        .pattern_length (length_reg),
        .anchor_start   (anchor_beg_reg),
        .anchor_end     (anchor_end_reg),
        .result         (core_result),
        .status         (status)
    );

    always_comb
    begin
        match_valid_next = match_valid_reg;
        if (advance && s1_last_reg)
            match_valid_next = 1'b1;
        else if (match_take)
            match_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_valid_reg <= 1'b0;
        else
            match_valid_reg <= match_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_last_reg)
            matched_reg <= core_result;
    end

    assign match_valid = match_valid_reg;
    assign matched     = matched_reg;

    `AWM_ASSERT_NOW(a_mid_word_flows, s1_valid_reg && !s1_last_reg, !word_stall, "mid-word beat stalled")
    `AWM_ASSERT_NEXT(a_last_gives_result, advance && s1_last_reg, match_valid, "word end lost its result")
    `AWM_ASSERT_NOW(a_start_clean, status.at_start, !status.found, "found flag set at word start")
    `AWM_ASSERT_NEXT(a_last_restarts, advance && s1_last_reg, status.at_start, "word state not restarted")

endmodule
